// File: rtl/core/tdbp_pkg.sv
// Shared constants, types and helpers for the tape data-bit pulse encoder.
`default_nettype none

package tdbp_pkg;

    // Default depth of one pulse sequence in the table.
    localparam int MAX_PULSES_DEF = 4;

    // Fixed field widths.
    localparam int BYTE_BITS  = 8;
    localparam int NBITS_W    = 4;
    localparam int CNT_W      = 3;
    localparam int SLOT_W     = 2;
    localparam int DUR_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Width of the sum used to form a table address before it is trimmed.
    localparam int ADDR_SUM_W = 5;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSES_ZERO = 2'd0,
        CFG_PULSES_ONE  = 2'd1,
        CFG_TAIL        = 2'd2,
        CFG_START_LEVEL = 2'd3
    } cfg_idx_t;

    // Request codes of an input beat.
    typedef enum logic {
        REQ_LOAD = 1'b0,
        REQ_DATA = 1'b1
    } req_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BITS,
        ST_TAIL
    } seq_state_t;

    // Configuration register contents.
    typedef struct packed {
        logic [CNT_W-1:0] pulses_for_zero;
        logic [CNT_W-1:0] pulses_for_one;
        logic [DUR_W-1:0] tail_duration;
        logic             start_level;
    } cfg_t;

    // Start of a data item, handed from the input port to the sequencer.
    typedef struct packed {
        logic                 go;
        logic [BYTE_BITS-1:0] data_byte;
        logic [NBITS_W-1:0]   valid_bits;
        logic                 first_byte;
        logic                 last_byte;
    } seq_start_t;

    // Pulse attributes that travel alongside a table read.
    typedef struct packed {
        logic level;
        logic is_tail;
        logic last_of_run;
    } pulse_meta_t;

    // Pulse issued by the sequencer; it lands in the output queue in the next cycle.
    typedef struct packed {
        logic        valid;
        pulse_meta_t meta;
    } pulse_push_t;

    // One finished pulse in the output queue.
    typedef struct packed {
        logic [DUR_W-1:0] duration;
        pulse_meta_t      meta;
    } pulse_t;

    // Clamp a configured pulse count to the table depth.
    function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] cnt,
                                                   input int max_p);
        logic [CNT_W-1:0] res;
        res = (int'(cnt) > max_p) ? CNT_W'(max_p) : cnt;
        return res;
    endfunction

    // Table address of a symbol's pulse slot.
    function automatic logic [ADDR_SUM_W-1:0] table_addr(input logic sym,
                                                         input logic [CNT_W-1:0] slot,
                                                         input int max_p);
        logic [ADDR_SUM_W-1:0] res;
        res = (sym ? ADDR_SUM_W'(max_p) : ADDR_SUM_W'(0)) + ADDR_SUM_W'(slot);
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/tdbp_if.sv
// Valid/ready channel interfaces for data beats in and pulse beats out.
`default_nettype none

interface tdbp_in_if
    import tdbp_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic                 table_symbol;
    logic [SLOT_W-1:0]    table_slot;
    logic [DUR_W-1:0]     table_duration;
    logic [BYTE_BITS-1:0] data_byte;
    logic [NBITS_W-1:0]   valid_bits;
    logic                 first_byte;
    logic                 last_byte;

    modport source (
        output valid, req_type, table_symbol, table_slot, table_duration,
               data_byte, valid_bits, first_byte, last_byte,
        input  ready
    );

    modport sink (
        input  valid, req_type, table_symbol, table_slot, table_duration,
               data_byte, valid_bits, first_byte, last_byte,
        output ready
    );
endinterface

interface tdbp_out_if
    import tdbp_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [DUR_W-1:0] pulse_duration;
    logic             pulse_level;
    logic             is_tail;
    logic             last_of_run;

    modport source (
        output valid, pulse_duration, pulse_level, is_tail, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, pulse_duration, pulse_level, is_tail, last_of_run,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/tdbp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tdbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/core/tdbp_seq.sv
// Bit and pulse sequencer: walks the byte, reads the pulse table, tracks the level.
`default_nettype none

module tdbp_seq
    import tdbp_pkg::*;
#(
    parameter int MAX_PULSES = MAX_PULSES_DEF,
    localparam int ADDR_W = $clog2(2 * MAX_PULSES)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire seq_start_t        start,
    input  wire logic              room,
    output logic                   idle,
    output logic                   rd_en,
    output logic      [ADDR_W-1:0] rd_addr,
    output pulse_push_t            push
);

    seq_state_t           state_reg, state_next;
    logic [BYTE_BITS-1:0] bits_reg, bits_next;
    logic [NBITS_W-1:0]   nbits_reg, nbits_next;
    logic [CNT_W-1:0]     pidx_reg, pidx_next;
    logic                 last_reg, last_next;
    logic                 level_reg, level_next;
    logic                 inflight_reg, inflight_next;
    pulse_meta_t          meta_reg, meta_next;

    logic                  bit_now;
    logic [CNT_W-1:0]      cnt_zero;
    logic [CNT_W-1:0]      cnt_one;
    logic [CNT_W-1:0]      cnt_now;
    logic                  bit_has_pulse;
    logic                  last_pulse_of_bit;
    logic                  more_after;
    logic                  issue;
    logic [ADDR_SUM_W-1:0] addr_sum;

    // Pulse counts clamped to the table depth.
    assign cnt_zero      = sat_count(cfg.pulses_for_zero, MAX_PULSES);
    assign cnt_one       = sat_count(cfg.pulses_for_one, MAX_PULSES);
    assign bit_now       = bits_reg[BYTE_BITS-1];
    assign cnt_now       = bit_now ? cnt_one : cnt_zero;
    assign bit_has_pulse = (cnt_now != '0);
    assign last_pulse_of_bit = ((pidx_reg + CNT_W'(1)) == cnt_now);

    // Whether any later bit of this byte still produces a pulse.
    always_comb
    begin
        more_after = 1'b0;
        for (int j = 1; j < BYTE_BITS; j++)
        begin
            if ((NBITS_W'(j) < nbits_reg) &&
                (bits_reg[BYTE_BITS-1-j] ? (cnt_one != '0) : (cnt_zero != '0)))
            begin
                more_after = 1'b1;
            end
        end
    end

    // A pulse is issued when the output queue can take it next cycle.
    always_comb
    begin
        issue = 1'b0;
        if (state_reg == ST_BITS)
        begin
            issue = (nbits_reg != '0) && bit_has_pulse && room;
        end
        else if (state_reg == ST_TAIL)
        begin
            issue = room;
        end
    end

    assign addr_sum = table_addr(bit_now, pidx_reg, MAX_PULSES);
    assign rd_addr  = addr_sum[ADDR_W-1:0];
    assign rd_en    = issue && (state_reg == ST_BITS);
    assign idle     = (state_reg == ST_IDLE);
    assign push     = '{valid: inflight_reg, meta: meta_reg};

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start.go)
                begin
                    state_next = ST_BITS;
                end
            end
            ST_BITS:
            begin
                if (nbits_reg == '0)
                begin
                    state_next = last_reg ? ST_TAIL : ST_IDLE;
                end
            end
            ST_TAIL:
            begin
                if (room)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and issued pulse attributes.
    always_comb
    begin
        bits_next     = bits_reg;
        nbits_next    = nbits_reg;
        pidx_next     = pidx_reg;
        last_next     = last_reg;
        level_next    = level_reg;
        inflight_next = issue;
        meta_next     = meta_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start.go)
                begin
                    bits_next  = start.data_byte;
                    nbits_next = (start.valid_bits > NBITS_W'(BYTE_BITS)) ?
                                 NBITS_W'(BYTE_BITS) : start.valid_bits;
                    pidx_next  = '0;
                    last_next  = start.last_byte;
                    if (start.first_byte)
                    begin
                        level_next = cfg.start_level;
                    end
                end
            end
            ST_BITS:
            begin
                if (nbits_reg != '0)
                begin
                    if (!bit_has_pulse)
                    begin
                        bits_next  = {bits_reg[BYTE_BITS-2:0], 1'b0};
                        nbits_next = nbits_reg - NBITS_W'(1);
                        pidx_next  = '0;
                    end
                    else if (room)
                    begin
                        meta_next.level       = level_reg;
                        meta_next.is_tail     = 1'b0;
                        meta_next.last_of_run = last_pulse_of_bit && !more_after && !last_reg;
                        level_next            = !level_reg;
                        if (last_pulse_of_bit)
                        begin
                            bits_next  = {bits_reg[BYTE_BITS-2:0], 1'b0};
                            nbits_next = nbits_reg - NBITS_W'(1);
                            pidx_next  = '0;
                        end
                        else
                        begin
                            pidx_next = pidx_reg + CNT_W'(1);
                        end
                    end
                end
            end
            ST_TAIL:
            begin
                if (room)
                begin
                    meta_next.level       = level_reg;
                    meta_next.is_tail     = 1'b1;
                    meta_next.last_of_run = 1'b1;
                end
            end
            default:
            begin
                inflight_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            level_reg    <= 1'b0;
            inflight_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            level_reg    <= level_next;
            inflight_reg <= inflight_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        bits_reg  <= bits_next;
        nbits_reg <= nbits_next;
        pidx_reg  <= pidx_next;
        last_reg  <= last_next;
        meta_reg  <= meta_next;
    end

    // A first byte reloads the level from the start-level register.
    a_first_level: assert property (@(posedge clk) disable iff (!rst_n)
        (start.go && idle && start.first_byte) |=> (level_reg == $past(cfg.start_level)))
        else $error("level not reloaded on first byte");

    // Table reads happen only while bits are being walked.
    a_read_state: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (state_reg == ST_BITS))
        else $error("table read outside bit walk");

    // Every data pulse flips the level after it.
    a_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (level_reg != $past(level_reg)))
        else $error("level did not toggle after a data pulse");

endmodule

`default_nettype wire

// File: rtl/core/tdbp_obuf.sv
// Two-entry output queue that joins table read data with pulse attributes.
`default_nettype none

module tdbp_obuf
    import tdbp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pulse_push_t       push,
    input  wire logic [DUR_W-1:0]  rd_data,
    input  wire logic [DUR_W-1:0]  tail_duration,
    output logic                   room,
    tdbp_out_if.source             pulse_out
);

    pulse_t     entries [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] occ_reg, occ_next;
    logic       pop;
    logic [2:0] used;
    pulse_t     landing;
    pulse_t     head;

    // Pulse landing from the table read, or the tail pulse.
    always_comb
    begin
        landing.meta     = push.meta;
        landing.duration = push.meta.is_tail ? tail_duration : rd_data;
    end

    assign head = entries[rd_ptr_reg];
    assign pop  = pulse_out.valid && pulse_out.ready;

    // Room for a pulse issued now, counting the one still in flight.
    assign used = 3'(occ_reg) + 3'(push.valid);
    assign room = (used < (3'd2 + 3'(pop)));

    // Pointer and fill updates.
    always_comb
    begin
        wr_ptr_next = push.valid ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        occ_next    = occ_reg + 2'(push.valid) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            occ_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            entries[wr_ptr_reg] <= landing;
        end
    end

    assign pulse_out.valid          = (occ_reg != 2'd0);
    assign pulse_out.pulse_duration = head.duration;
    assign pulse_out.pulse_level    = head.meta.level;
    assign pulse_out.is_tail        = head.meta.is_tail;
    assign pulse_out.last_of_run    = head.meta.last_of_run;

    // A pulse never lands in a full queue unless one leaves in the same cycle.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.valid && (occ_reg == 2'd2)) |-> pop)
        else $error("pulse landed in a full output queue");

endmodule

`default_nettype wire

// File: rtl/core/tape_data_bits_to_pulses.sv
// Top level of the tape data-bit pulse encoder.
// A data item's pulses come from a registered table read through the output queue.
// Throughput: one pulse per cycle while the output queue has room; bits with no
// pulses take a step of their own, and a new item is taken only once the sequencer
// is idle again. Table loads are taken while idle and write straight into the RAM.
// Reset restores level, control and config; data regs and table are not cleared.
`default_nettype none

module tape_data_bits_to_pulses
    import tdbp_pkg::*;
#(
    parameter int MAX_PULSES = MAX_PULSES_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    tdbp_in_if.sink                    data_in,
    tdbp_out_if.source                 pulse_out,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int DEPTH  = 2 * MAX_PULSES;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [CNT_W-1:0] pulses_for_zero_reg;
    logic [CNT_W-1:0] pulses_for_one_reg;
    logic [DUR_W-1:0] tail_duration_reg;
    logic             start_level_reg;
    cfg_t             cfg;

    logic                  idle;
    logic                  in_accept;
    logic                  load_we;
    logic [ADDR_SUM_W-1:0] load_sum;
    seq_start_t            start;
    logic                  room;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DUR_W-1:0]      rd_data;
    pulse_push_t           push;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulses_for_zero_reg <= CNT_W'(2);
            pulses_for_one_reg  <= CNT_W'(2);
            tail_duration_reg   <= '0;
            start_level_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_PULSES_ZERO: pulses_for_zero_reg <= cfg_wdata[CNT_W-1:0];
                CFG_PULSES_ONE:  pulses_for_one_reg  <= cfg_wdata[CNT_W-1:0];
                CFG_TAIL:        tail_duration_reg   <= cfg_wdata[DUR_W-1:0];
                CFG_START_LEVEL: start_level_reg     <= cfg_wdata[0];
                default:         start_level_reg     <= start_level_reg;
            endcase
        end
    end

    assign cfg = '{pulses_for_zero: pulses_for_zero_reg,
                   pulses_for_one:  pulses_for_one_reg,
                   tail_duration:   tail_duration_reg,
                   start_level:     start_level_reg};

    // Input beats are taken while the sequencer is idle.
    assign data_in.ready = idle;
    assign in_accept     = data_in.valid && idle;

    // Table loads write straight into the RAM; slots past the depth are dropped.
    assign load_we  = in_accept && (req_t'(data_in.req_type) == REQ_LOAD) &&
                      (int'(data_in.table_slot) < MAX_PULSES);
    assign load_sum = table_addr(data_in.table_symbol, CNT_W'(data_in.table_slot), MAX_PULSES);

    assign start = '{go:         in_accept && (req_t'(data_in.req_type) == REQ_DATA),
                     data_byte:  data_in.data_byte,
                     valid_bits: data_in.valid_bits,
                     first_byte: data_in.first_byte,
                     last_byte:  data_in.last_byte};

    tdbp_ram #(
        .WIDTH (DUR_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_sum[ADDR_W-1:0]),
        .wdata (data_in.table_duration),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    tdbp_seq #(
        .MAX_PULSES (MAX_PULSES)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .start   (start),
        .room    (room),
        .idle    (idle),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .push    (push)
    );

    tdbp_obuf u_obuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .rd_data       (rd_data),
        .tail_duration (tail_duration_reg),
        .room          (room),
        .pulse_out     (pulse_out)
    );

endmodule

`default_nettype wire
